// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion checked at every clock edge outside reset.
`define PES_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Assertion whose consequent is checked in the cycle after its antecedent.
`define PES_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/pes_pkg.sv -----
`default_nettype none

package pes_pkg;

  localparam int MAX_ELEMENTS_DEFAULT = 64;

  localparam logic [63:0] SIGN64  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ONE64   = 64'd1;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } pes_in_t;

  typedef struct packed {
    logic signed [63:0] product;
    logic               last_result;
    logic               short_set;
    logic               dropped_extra;
  } pes_out_t;

  // Operand pairing for the shared multiplier.
  typedef enum logic [1:0] {
    MSEL_RUN_ELEM = 2'd0,
    MSEL_SUF_ELEM = 2'd1,
    MSEL_PRE_SUF  = 2'd2
  } pes_msel_t;

  typedef struct packed {
    logic      store;
    logic      fwd_init;
    logic      rd_fwd;
    logic      fwd_write;
    logic      bwd_init;
    logic      rd_bwd;
    logic      suf_write;
    logic      pre_write;
    logic      out_init;
    logic      rd_out;
    logic      out_load_full;
    logic      out_load_short;
    logic      end_run;
    logic      mul_start;
    pes_msel_t mul_sel;
  } pes_cmd_t;

  typedef struct packed {
    logic count_lt2;
    logic idx_end;
    logic idx_one;
    logic mul_done;
    logic out_free;
  } pes_status_t;

endpackage

`default_nettype wire

// ----- sv/pes_mul.sv -----
`default_nettype none
`include "assert_macros.svh"

// Saturating signed 64x64 multiplier. The magnitudes are multiplied as four
// 32x32 partial products, one per cycle, into a 128-bit accumulator; the
// result is then clamped to the signed 64-bit range and the sign applied.
module pes_mul
  import pes_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] res
);

  logic         busy;
  logic [2:0]   step;
  logic [63:0]  ma;
  logic [63:0]  mb;
  logic         neg;
  logic [63:0]  pp;
  logic [1:0]   pp_shift;
  logic [127:0] acc;
  logic [31:0]  a_part;
  logic [31:0]  b_part;
  logic [63:0]  pp_comb;
  logic [1:0]   shift_comb;
  logic [127:0] pp_ext;
  logic [63:0]  limit;
  logic         sat;
  logic [63:0]  mag;

  assign a_part     = step[1] ? ma[63:32] : ma[31:0];
  assign b_part     = step[0] ? mb[63:32] : mb[31:0];
  assign pp_comb    = {32'd0, a_part} * {32'd0, b_part};
  assign shift_comb = {1'b0, step[1]} + {1'b0, step[0]};

  always_comb begin
    case (pp_shift)
      2'd0:    pp_ext = {64'd0, pp};
      2'd1:    pp_ext = {32'd0, pp, 32'd0};
      2'd2:    pp_ext = {pp, 64'd0};
      default: pp_ext = '0;
    endcase
  end

  // A negative result may reach the most negative value, one beyond the
  // largest positive one.
  assign limit = neg ? SIGN64 : MAX_POS;
  assign sat   = (acc[127:64] != 64'd0) || (acc[63:0] > limit);
  assign mag   = sat ? limit : acc[63:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 3'd1;
        if (step == 3'd5) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma  <= a[63] ? (64'd0 - a) : a;
      mb  <= b[63] ? (64'd0 - b) : b;
      neg <= a[63] ^ b[63];
      acc <= '0;
    end else if (busy) begin
      if (step <= 3'd3) begin
        pp       <= pp_comb;
        pp_shift <= shift_comb;
      end
      if (step >= 3'd1 && step <= 3'd4) begin
        acc <= acc + pp_ext;
      end
      if (step == 3'd5) begin
        res <= neg ? (64'd0 - mag) : mag;
      end
    end
  end

  `PES_ASSERT(a_mul_no_restart, clk, rst, start |-> !busy, "multiplier started while busy")

endmodule

`default_nettype wire

// ----- sv/pes_dp.sv -----
`default_nettype none
`include "assert_macros.svh"

module pes_dp
  import pes_pkg::*;
#(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  pes_in_t     item,
  input  pes_cmd_t    cmd,
  output pes_status_t status,
  output pes_out_t    result,
  output logic        result_valid,
  input  logic        result_ready
);

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ELEMENTS);
  localparam logic [CW-1:0] ONE_CNT = CW'(1);
  localparam logic [CW-1:0] TWO_CNT = CW'(2);

  logic [31:0] elem_mem [MAX_ELEMENTS];
  logic [63:0] pre_mem  [MAX_ELEMENTS];

  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] idx_m1;
  logic [CW-1:0] last_idx;
  logic          ovf;
  logic [63:0]   run;
  logic [63:0]   suffix;
  logic [31:0]   elem_rd;
  logic [63:0]   pre_rd;
  logic [63:0]   elem_ext;

  logic [AW-1:0] elem_raddr;
  logic [AW-1:0] pre_raddr;
  logic [AW-1:0] pre_waddr;
  logic [63:0]   pre_wdata;
  logic          pre_we;

  logic [63:0] mul_a;
  logic [63:0] mul_b;
  logic        mul_done;
  logic [63:0] mul_res;

  logic out_free;
  logic room;

  assign idx_m1   = idx - ONE_CNT;
  assign last_idx = count - ONE_CNT;
  assign room     = (count < MAX_CNT);
  assign elem_ext = {{32{elem_rd[31]}}, elem_rd};
  assign out_free = !result_valid || result_ready;

  assign elem_raddr = cmd.rd_bwd ? idx[AW-1:0] : idx_m1[AW-1:0];
  assign pre_raddr  = cmd.rd_bwd ? idx_m1[AW-1:0] : idx[AW-1:0];

  always_comb begin
    pre_we    = cmd.fwd_init || cmd.fwd_write || cmd.pre_write;
    pre_waddr = idx[AW-1:0];
    pre_wdata = mul_res;
    if (cmd.fwd_init) begin
      pre_waddr = '0;
      pre_wdata = ONE64;
    end else if (cmd.pre_write) begin
      pre_waddr = idx_m1[AW-1:0];
    end
  end

  always_comb begin
    case (cmd.mul_sel)
      MSEL_RUN_ELEM: begin
        mul_a = run;
        mul_b = elem_ext;
      end
      MSEL_SUF_ELEM: begin
        mul_a = suffix;
        mul_b = elem_ext;
      end
      MSEL_PRE_SUF: begin
        mul_a = pre_rd;
        mul_b = suffix;
      end
      default: begin
        mul_a = run;
        mul_b = elem_ext;
      end
    endcase
  end

  pes_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  // Element and prefix memories, one write and one registered read each.
  always_ff @(posedge clk) begin
    if (cmd.store && room) begin
      elem_mem[count[AW-1:0]] <= item.value;
    end
    if (cmd.rd_fwd || cmd.rd_bwd) begin
      elem_rd <= elem_mem[elem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (pre_we) begin
      pre_mem[pre_waddr] <= pre_wdata;
    end
    if (cmd.rd_bwd || cmd.rd_out) begin
      pre_rd <= pre_mem[pre_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      ovf          <= 1'b0;
      idx          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.store) begin
        if (room) begin
          count <= count + ONE_CNT;
        end else begin
          ovf <= 1'b1;
        end
      end
      if (cmd.end_run) begin
        count <= '0;
        ovf   <= 1'b0;
      end

      if (cmd.fwd_init) begin
        idx <= ONE_CNT;
      end else if (cmd.fwd_write || cmd.out_load_full) begin
        idx <= idx + ONE_CNT;
      end else if (cmd.bwd_init) begin
        idx <= last_idx;
      end else if (cmd.pre_write) begin
        idx <= idx_m1;
      end else if (cmd.out_init) begin
        idx <= '0;
      end

      if (cmd.out_load_full || cmd.out_load_short) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fwd_init) begin
      run <= ONE64;
    end else if (cmd.fwd_write) begin
      run <= mul_res;
    end
    if (cmd.bwd_init) begin
      suffix <= ONE64;
    end else if (cmd.suf_write) begin
      suffix <= mul_res;
    end
    if (cmd.out_load_full) begin
      result.product       <= pre_rd;
      result.last_result   <= (idx == last_idx);
      result.short_set     <= 1'b0;
      result.dropped_extra <= ovf;
    end else if (cmd.out_load_short) begin
      result.product       <= '0;
      result.last_result   <= 1'b1;
      result.short_set     <= 1'b1;
      result.dropped_extra <= ovf;
    end
  end

  assign status.count_lt2 = (count < TWO_CNT);
  assign status.idx_end   = (idx == last_idx);
  assign status.idx_one   = (idx == ONE_CNT);
  assign status.mul_done  = mul_done;
  assign status.out_free  = out_free;

  `PES_ASSERT(a_count_bound, clk, rst, count <= MAX_CNT, "element count beyond capacity")
  `PES_ASSERT(a_out_load_free, clk, rst, (cmd.out_load_full || cmd.out_load_short) |-> out_free, "result register overwritten")
  `PES_ASSERT_NEXT(a_end_clears, clk, rst, cmd.end_run, (count == '0) && !ovf, "run state not cleared")

endmodule

`default_nettype wire

// ----- sv/pes_ctrl.sv -----
`default_nettype none
`include "assert_macros.svh"

module pes_ctrl
  import pes_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_last,
  output logic        item_ready,
  input  pes_status_t status,
  output pes_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_LOAD,
    S_START,
    S_FWD_RD,
    S_FWD_MUL,
    S_FWD_WAIT,
    S_BWD_INIT,
    S_BWD_RD,
    S_BWD_MUL1,
    S_BWD_W1,
    S_BWD_MUL2,
    S_BWD_W2,
    S_OUT_INIT,
    S_OUT_RD,
    S_OUT_PUT,
    S_SHORT
  } state_t;

  state_t state;
  state_t state_next;

  assign item_ready = (state == S_LOAD);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.store  = item_valid && item_ready;
    case (state)
      S_LOAD: begin
        if (item_valid && item_last) begin
          state_next = S_START;
        end
      end
      S_START: begin
        if (status.count_lt2) begin
          state_next = S_SHORT;
        end else begin
          cmd.fwd_init = 1'b1;
          state_next   = S_FWD_RD;
        end
      end
      S_FWD_RD: begin
        cmd.rd_fwd = 1'b1;
        state_next = S_FWD_MUL;
      end
      S_FWD_MUL: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MSEL_RUN_ELEM;
        state_next    = S_FWD_WAIT;
      end
      S_FWD_WAIT: begin
        if (status.mul_done) begin
          cmd.fwd_write = 1'b1;
          state_next    = status.idx_end ? S_BWD_INIT : S_FWD_RD;
        end
      end
      S_BWD_INIT: begin
        cmd.bwd_init = 1'b1;
        state_next   = S_BWD_RD;
      end
      S_BWD_RD: begin
        cmd.rd_bwd = 1'b1;
        state_next = S_BWD_MUL1;
      end
      S_BWD_MUL1: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MSEL_SUF_ELEM;
        state_next    = S_BWD_W1;
      end
      S_BWD_W1: begin
        if (status.mul_done) begin
          cmd.suf_write = 1'b1;
          state_next    = S_BWD_MUL2;
        end
      end
      S_BWD_MUL2: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MSEL_PRE_SUF;
        state_next    = S_BWD_W2;
      end
      S_BWD_W2: begin
        if (status.mul_done) begin
          cmd.pre_write = 1'b1;
          state_next    = status.idx_one ? S_OUT_INIT : S_BWD_RD;
        end
      end
      S_OUT_INIT: begin
        cmd.out_init = 1'b1;
        state_next   = S_OUT_RD;
      end
      S_OUT_RD: begin
        cmd.rd_out = 1'b1;
        state_next = S_OUT_PUT;
      end
      S_OUT_PUT: begin
        if (status.out_free) begin
          cmd.out_load_full = 1'b1;
          if (status.idx_end) begin
            cmd.end_run = 1'b1;
            state_next  = S_LOAD;
          end else begin
            state_next = S_OUT_RD;
          end
        end
      end
      S_SHORT: begin
        if (status.out_free) begin
          cmd.out_load_short = 1'b1;
          cmd.end_run        = 1'b1;
          state_next         = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  `PES_ASSERT(a_done_in_wait, clk, rst, status.mul_done |-> (state == S_FWD_WAIT || state == S_BWD_W1 || state == S_BWD_W2), "multiplier result arrived outside a wait state")

endmodule

`default_nettype wire

// ----- sv/product_except_self_unit.sv -----
// Loads one element per cycle while ready; the set ends at the transaction marked last.
// A set of n >= 2 elements then runs a forward pass and a backward pass to its first
// result, one multiply per forward step and two per backward step, as each multiply
// holds the controller until done. Results then leave one at a time as the result
// register frees; a short set gives its single result after the last transaction.
// Synchronous active-high reset returns the controller to loading with an empty set.
`default_nettype none

module product_except_self_unit
  import pes_pkg::*;
#(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_ready,
  input  pes_in_t  item,
  output logic     result_valid,
  input  logic     result_ready,
  output pes_out_t result
);

  pes_cmd_t    cmd;
  pes_status_t status;

  pes_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_last  (item.last),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  pes_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .status       (status),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

endmodule

`default_nettype wire
